@@ sv/qdc_pkg.sv @@
// Package for the quantized depthwise convolution MAC block.
// Holds widths, the configuration struct, queue entry and state types.
// No dependencies; every other file of the block imports it.
`default_nettype none
package qdc_pkg;

  localparam int ACC_BITS  = 32;
  localparam int MULT_W    = 31;
  localparam int SHIFT_W   = 6;
  localparam int DIM_W     = 16;
  localparam int COORD_W   = 17;
  localparam int BYTE_W    = 8;
  localparam int BIAS_W    = 32;
  localparam int PROD_W    = 18;
  localparam int SCALED_W  = ACC_BITS + MULT_W;
  localparam int CAP_W     = 13;
  localparam int REQ_CAP   = 4096;
  localparam int OUT_MAX   = 255;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 31;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_ZP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ZP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ZP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MUL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd6;

  typedef struct packed {
    logic [BYTE_W-1:0]  input_zero_point;
    logic [BYTE_W-1:0]  weight_zero_point;
    logic [BYTE_W-1:0]  output_zero_point;
    logic [MULT_W-1:0]  scale_multiplier;
    logic [SHIFT_W-1:0] scale_shift;
    logic [DIM_W-1:0]   image_height;
    logic [DIM_W-1:0]   image_width;
  } cfg_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic signed [BIAS_W-1:0] bias;
    logic                     last;
  } q_entry_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_MAG,
    ST_MUL,
    ST_SHIFT,
    ST_DONE
  } back_state_t;

endpackage
`default_nettype wire

@@ sv/quantized_depthwise_conv_mac_top.sv @@
// Top level of the quantized depthwise convolution MAC block.
// Holds the configuration registers; depends on qdc_pkg, qdc_front, qdc_fifo, qdc_back.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    sample weight tap_row tap_col channel_bias last_tap
//   out      out_valid/out_ready  out_value
//   cfg      cfg_we               cfg_index cfg_data
//
// A tap that is not last is added in the accumulator, so taps stream at one per cycle
// while the back end is in its run state. A last tap adds the requantize steps (magnitude,
// 32x31 multiply, round and shift, zero point and clamp) in the back end sequencer.
// Reset clears the accumulator, queue and output valid flag and loads register defaults.
// The two-entry queue takes up to two more taps while the back end requantizes
// or waits on out_ready; after that in_ready drops until the back end pops.
`default_nettype none
module quantized_depthwise_conv_mac_top import qdc_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [BYTE_W-1:0]         sample,
  input  wire logic [BYTE_W-1:0]         weight,
  input  wire logic signed [COORD_W-1:0] tap_row,
  input  wire logic signed [COORD_W-1:0] tap_col,
  input  wire logic signed [BIAS_W-1:0]  channel_bias,
  input  wire logic                      last_tap,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [BYTE_W-1:0]              out_value,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DAT_W-1:0]      cfg_data
);

  cfg_t     cfg;
  q_entry_t front_entry;
  q_entry_t q_data;
  logic     q_valid;
  logic     q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_zero_point  <= '0;
      cfg.weight_zero_point <= '0;
      cfg.output_zero_point <= '0;
      cfg.scale_multiplier  <= MULT_W'(1073741824);
      cfg.scale_shift       <= SHIFT_W'(30);
      cfg.image_height      <= DIM_W'(1);
      cfg.image_width       <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INPUT_ZP:  cfg.input_zero_point  <= cfg_data[BYTE_W-1:0];
        REG_WEIGHT_ZP: cfg.weight_zero_point <= cfg_data[BYTE_W-1:0];
        REG_OUTPUT_ZP: cfg.output_zero_point <= cfg_data[BYTE_W-1:0];
        REG_SCALE_MUL: cfg.scale_multiplier  <= cfg_data[MULT_W-1:0];
        REG_SCALE_SHR: cfg.scale_shift       <= cfg_data[SHIFT_W-1:0];
        REG_HEIGHT:    cfg.image_height      <= cfg_data[DIM_W-1:0];
        REG_WIDTH:     cfg.image_width       <= cfg_data[DIM_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  qdc_front u_front (
    .cfg          (cfg),
    .sample       (sample),
    .weight       (weight),
    .tap_row      (tap_row),
    .tap_col      (tap_col),
    .channel_bias (channel_bias),
    .last_tap     (last_tap),
    .entry        (front_entry)
  );

  qdc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  qdc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value)
  );

endmodule
`default_nettype wire

@@ sv/qdc_front.sv @@
// Front end: bounds check for padding and the per-tap product.
// Depends on qdc_pkg; feeds qdc_fifo.
`default_nettype none
module qdc_front import qdc_pkg::*; (
  input  wire cfg_t                       cfg,
  input  wire logic [BYTE_W-1:0]          sample,
  input  wire logic [BYTE_W-1:0]          weight,
  input  wire logic signed [COORD_W-1:0]  tap_row,
  input  wire logic signed [COORD_W-1:0]  tap_col,
  input  wire logic signed [BIAS_W-1:0]   channel_bias,
  input  wire logic                       last_tap,
  output q_entry_t                        entry
);

  logic                    row_ok;
  logic                    col_ok;
  logic signed [BYTE_W:0]  s_diff;
  logic signed [BYTE_W:0]  w_diff;
  logic signed [PROD_W-1:0] prod;

  // non-negative coordinate: its low bits compare directly against the size
  assign row_ok = !tap_row[COORD_W-1] && (tap_row[DIM_W-1:0] < cfg.image_height);
  assign col_ok = !tap_col[COORD_W-1] && (tap_col[DIM_W-1:0] < cfg.image_width);

  assign s_diff = $signed({1'b0, sample}) - $signed({1'b0, cfg.input_zero_point});
  assign w_diff = $signed({1'b0, weight}) - $signed({1'b0, cfg.weight_zero_point});
  assign prod   = PROD_W'(s_diff * w_diff);

  always_comb begin
    entry.prod = (row_ok && col_ok) ? prod : '0;
    entry.bias = channel_bias;
    entry.last = last_tap;
  end

endmodule
`default_nettype wire

@@ sv/qdc_fifo.sv @@
// Short queue between the front end and the accumulate/requantize back end.
// Depends on qdc_pkg for the entry type and depth.
`default_nettype none
module qdc_fifo import qdc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push_valid,
  output logic          push_ready,
  input  wire q_entry_t push_data,
  output logic          pop_valid,
  input  wire logic     pop_ready,
  output q_entry_t      pop_data
);

  q_entry_t             mem [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QPTR_W:0]      count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/qdc_back.sv @@
// Back end: accumulator, requantize sequencer and output register.
// Depends on qdc_pkg; pops entries from qdc_fifo.
`default_nettype none
module qdc_back import qdc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     q_valid,
  output logic          q_ready,
  input  wire q_entry_t q_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [BYTE_W-1:0] out_value
);

  back_state_t               state;
  back_state_t               state_next;
  logic signed [ACC_BITS-1:0] acc;
  logic signed [ACC_BITS-1:0] acc_sum;
  logic [ACC_BITS-1:0]       mag;
  logic                      neg;
  logic [SCALED_W-1:0]       scaled;
  logic [CAP_W-1:0]          capped;
  logic [SCALED_W:0]         rnd_inc;
  logic [SCALED_W:0]         rounded;
  logic [SCALED_W:0]         shifted;
  logic [CAP_W-1:0]          cap_next;
  logic signed [CAP_W:0]     signed_val;
  logic signed [CAP_W+1:0]   total;
  logic [BYTE_W-1:0]         byte_next;
  logic                      take;
  logic                      load_out;

  assign take     = (state == ST_RUN) && q_valid;
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    acc_sum = acc + ACC_BITS'(q_data.prod)
            + (q_data.last ? ACC_BITS'(q_data.bias) : ACC_BITS'(0));
  end

  // round half away from zero on the magnitude, then cap
  always_comb begin
    rnd_inc  = (cfg.scale_shift != '0) ?
               ((SCALED_W+1)'(1) << (cfg.scale_shift - 1'b1)) : '0;
    rounded  = {1'b0, scaled} + rnd_inc;
    shifted  = rounded >> cfg.scale_shift;
    cap_next = (shifted > (SCALED_W+1)'(REQ_CAP)) ? CAP_W'(REQ_CAP) : shifted[CAP_W-1:0];
  end

  always_comb begin
    signed_val = neg ? -$signed({1'b0, capped}) : $signed({1'b0, capped});
    total      = {signed_val[CAP_W], signed_val}
               + $signed({{(CAP_W+2-BYTE_W){1'b0}}, cfg.output_zero_point});
    if (total[CAP_W+1]) begin
      byte_next = '0;
    end else if (total > (CAP_W+2)'(OUT_MAX)) begin
      byte_next = BYTE_W'(OUT_MAX);
    end else begin
      byte_next = total[BYTE_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = (state == ST_RUN);
    case (state)
      ST_RUN: begin
        if (q_valid && q_data.last) begin
          state_next = ST_MAG;
        end
      end
      ST_MAG:   state_next = ST_MUL;
      ST_MUL:   state_next = ST_SHIFT;
      ST_SHIFT: state_next = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        acc <= acc_sum;
      end else if (state == ST_MAG) begin
        acc <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MAG) begin
      neg <= acc[ACC_BITS-1];
      mag <= acc[ACC_BITS-1] ? ACC_BITS'(-acc) : ACC_BITS'(acc);
    end
    if (state == ST_MUL) begin
      scaled <= SCALED_W'(mag * cfg.scale_multiplier);
    end
    if (state == ST_SHIFT) begin
      capped <= cap_next;
    end
    if (load_out) begin
      out_value <= byte_next;
    end
  end

endmodule
`default_nettype wire
